@@ src/lhcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lhcc_pkg: shared constants and types of the LRU cache cost counter
// Entry geometry, cost values, register map and controller command bundle.
// ----------------------------------------------------------------------------
package lhcc_pkg;

  // Entry array geometry
  localparam int unsigned MaxEntries = 32;
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned AgeW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);

  // Field widths
  localparam int unsigned SizeW = 6;
  localparam int unsigned CostW = 3;
  localparam int unsigned SumW  = 32;

  // Oldest age an entry can reach
  localparam logic [AgeW-1:0] AgeMax = AgeW'(MaxEntries - 1);

  // Access costs
  localparam logic [CostW-1:0] HitCost  = 3'd1;
  localparam logic [CostW-1:0] MissCost = 3'd5;

  // Register map (index = byte address / 4)
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        CfgIdxCacheSize = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the key of a new beat
    logic lookup;  // compare key, pick target entry
    logic update;  // apply ages, keys, costs and emit the result
  } lhcc_cmd_t;

endpackage

@@ src/lru_cache_hit_cost_counter_core.sv @@
// ----------------------------------------------------------------------------
// lru_cache_hit_cost_counter_core: fully associative LRU cache cost counter
// Looks up 64-bit keys in a 32-entry LRU cache and keeps a saturating total
// of access costs (1 per hit, 5 per miss).
// ----------------------------------------------------------------------------
// Each key accepted on start (while busy is low) goes through a lookup cycle,
// which compares it against all entries at once, and then an update cycle,
// which updates the recency ranks, the entry keys and the running total.
// The next key is accepted during that update cycle, while the previous
// key is still updating, and busy is high in the cycle after each acceptance.
// The result (hit_o, access_cost_o, total_cost_o) is shown for exactly one
// cycle with result_valid_o high, registered from the update cycle; it cannot
// be held off, so capture it on the strobe. Writing cache_size flushes every
// entry but keeps the total; write it only when no access is in flight.
module lru_cache_hit_cost_counter_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Access command
  input  logic                                start,
  output logic                                busy,
  input  logic [lhcc_pkg::KeyBits-1:0]        city_key_i,
  // Result beat
  output logic                                result_valid_o,
  output logic                                hit_o,
  output logic [lhcc_pkg::CostW-1:0]          access_cost_o,
  output logic [lhcc_pkg::SumW-1:0]           total_cost_o,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lhcc_pkg::CfgAddrW-1:0]       paddr,
  input  logic [lhcc_pkg::CfgDataW-1:0]       pwdata,
  output logic [lhcc_pkg::CfgDataW-1:0]       prdata,
  output logic                                pready
);

  lhcc_pkg::lhcc_cmd_t        cmd;
  logic [lhcc_pkg::SizeW-1:0] cache_size;
  logic                       size_wr;

  // Configuration registers
  lhcc_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .cache_size_o (cache_size),
    .size_wr_o    (size_wr)
  );

  // Sequencer
  lhcc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Entry array and accumulator
  lhcc_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .city_key_i     (city_key_i),
    .cache_size_i   (cache_size),
    .flush_i        (size_wr),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .access_cost_o  (access_cost_o),
    .total_cost_o   (total_cost_o)
  );

  // Every result beat comes from a preceding lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy, 2))
    else $error("result without a preceding lookup");

endmodule

@@ src/lhcc_regs.sv @@
// ----------------------------------------------------------------------------
// lhcc_regs: configuration register file
// Holds cache_size behind an APB-style port and flags every write of it.
// ----------------------------------------------------------------------------
module lhcc_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lhcc_pkg::CfgAddrW-1:0]       paddr,
  input  logic [lhcc_pkg::CfgDataW-1:0]       pwdata,
  output logic [lhcc_pkg::CfgDataW-1:0]       prdata,
  output logic                                pready,
  output logic [lhcc_pkg::SizeW-1:0]          cache_size_o,
  output logic                                size_wr_o
);

  logic [lhcc_pkg::SizeW-1:0] cache_size_q, cache_size_d;
  logic                       wr_en;
  logic                       sel_size;

  // Decode the access beat
  assign pready   = 1'b1;
  assign sel_size = (paddr[2] == lhcc_pkg::CfgIdxCacheSize);
  assign wr_en    = psel & penable & pwrite & pready;
  assign size_wr_o = wr_en & sel_size;

  // Capture a new size on write
  always_comb begin
    cache_size_d = cache_size_q;
    if (size_wr_o) begin
      cache_size_d = pwdata[lhcc_pkg::SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= '0;
    end else begin
      cache_size_q <= cache_size_d;
    end
  end

  // Read back
  assign prdata = sel_size ? {{(lhcc_pkg::CfgDataW - lhcc_pkg::SizeW){1'b0}}, cache_size_q}
                           : '0;

  assign cache_size_o = cache_size_q;

endmodule

@@ src/lhcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lhcc_ctrl: access sequencer
// Steps each accepted beat through a lookup cycle and an update cycle, and
// takes the next beat during the update cycle.
// ----------------------------------------------------------------------------
module lhcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output lhcc_pkg::lhcc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Accept whenever no lookup is in flight
  assign busy   = (state_q == ST_LOOKUP);
  assign accept = start & ~busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Drive datapath commands
  assign cmd_o.load   = accept;
  assign cmd_o.lookup = (state_q == ST_LOOKUP);
  assign cmd_o.update = (state_q == ST_UPDATE);

  // A lookup cycle is always followed by its update cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lookup |=> cmd_o.update)
    else $error("lookup not followed by update");

  // A lookup state is never followed by another lookup state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held past one cycle");

endmodule

@@ src/lhcc_dpath.sv @@
// ----------------------------------------------------------------------------
// lhcc_dpath: entry array, tag compare, age update and cost accumulator
// Keys sit in a 32-entry register array compared in parallel; ages hold a
// recency rank per entry, 0 being the most recent.
// ----------------------------------------------------------------------------
module lhcc_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lhcc_pkg::lhcc_cmd_t               cmd_i,
  input  logic [lhcc_pkg::KeyBits-1:0]      city_key_i,
  input  logic [lhcc_pkg::SizeW-1:0]        cache_size_i,
  input  logic                              flush_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [lhcc_pkg::CostW-1:0]        access_cost_o,
  output logic [lhcc_pkg::SumW-1:0]         total_cost_o
);

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_HIT     = 2'd1,
    OP_FILL    = 2'd2,
    OP_REPLACE = 2'd3
  } op_e;

  localparam int unsigned N = lhcc_pkg::MaxEntries;

  // Entry state
  logic [lhcc_pkg::KeyBits-1:0] keys_q [N];
  logic [N-1:0]                 valid_q, valid_d;
  logic [lhcc_pkg::AgeW-1:0]    age_q [N];
  logic [lhcc_pkg::AgeW-1:0]    age_d [N];
  logic [lhcc_pkg::CntW-1:0]    filled_q, filled_d;
  logic [lhcc_pkg::SumW-1:0]    sum_q, sum_d;

  // Beat state
  logic [lhcc_pkg::KeyBits-1:0] cur_key_q;
  op_e                          op_q, op_d;
  logic [lhcc_pkg::IdxW-1:0]    tgt_q, tgt_d;
  logic                         hit_q;
  logic                         result_valid_q;

  // Lookup signals
  logic [lhcc_pkg::CntW-1:0]    size;
  logic [N-1:0]                 match;
  logic [N-1:0]                 oldest;
  logic [lhcc_pkg::IdxW-1:0]    hit_idx;
  logic [lhcc_pkg::IdxW-1:0]    vic_idx;
  logic [lhcc_pkg::AgeW-1:0]    last_age;

  // Update signals
  logic [lhcc_pkg::AgeW-1:0]    pivot;
  logic [lhcc_pkg::CostW-1:0]   cost;
  logic [lhcc_pkg::SumW:0]      sum_ext;

  // Clamp the configured size to the array depth
  assign size = (cache_size_i > lhcc_pkg::CntW'(N)) ? lhcc_pkg::CntW'(N)
                                                   : lhcc_pkg::CntW'(cache_size_i);

  // Ages of the valid entries are a permutation of 0..filled-1, so the
  // least recent entry of a full cache is the one ranked filled-1
  assign last_age = lhcc_pkg::AgeW'(filled_q - lhcc_pkg::CntW'(1));

  // Parallel tag compare and victim search
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i]  = valid_q[i] && (keys_q[i] == cur_key_q);
      oldest[i] = valid_q[i] && (age_q[i] == last_age);
    end
  end

  // Pick the lowest matching index and the lowest index of the oldest entry
  always_comb begin
    hit_idx = '0;
    vic_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i])  hit_idx = lhcc_pkg::IdxW'(i);
      if (oldest[i]) vic_idx = lhcc_pkg::IdxW'(i);
    end
  end

  // Classify the access
  always_comb begin
    op_d  = op_q;
    tgt_d = tgt_q;
    if (cmd_i.lookup) begin
      if (size == '0) begin
        op_d  = OP_NONE;
        tgt_d = '0;
      end else if (|match) begin
        op_d  = OP_HIT;
        tgt_d = hit_idx;
      end else if (filled_q < size) begin
        op_d  = OP_FILL;
        tgt_d = lhcc_pkg::IdxW'(filled_q);
      end else begin
        op_d  = OP_REPLACE;
        tgt_d = vic_idx;
      end
    end
  end

  // Age, valid and fill count update
  assign pivot = age_q[tgt_q];

  always_comb begin
    valid_d  = valid_q;
    filled_d = filled_q;
    for (int i = 0; i < N; i++) begin
      age_d[i] = age_q[i];
    end
    if (flush_i) begin
      valid_d  = '0;
      filled_d = '0;
      for (int i = 0; i < N; i++) begin
        age_d[i] = '0;
      end
    end else if (cmd_i.update && (op_q != OP_NONE)) begin
      // Age every valid entry younger than the target; a fill ages them all
      for (int i = 0; i < N; i++) begin
        if (valid_q[i] && (lhcc_pkg::IdxW'(i) != tgt_q) &&
            ((op_q == OP_FILL) || (age_q[i] < pivot)) &&
            (age_q[i] != lhcc_pkg::AgeMax)) begin
          age_d[i] = age_q[i] + lhcc_pkg::AgeW'(1);
        end
      end
      age_d[tgt_q] = '0;
      if (op_q == OP_FILL) begin
        valid_d[tgt_q] = 1'b1;
        filled_d       = filled_q + lhcc_pkg::CntW'(1);
      end
    end
  end

  // Saturating cost accumulator
  assign cost    = (op_q == OP_HIT) ? lhcc_pkg::HitCost : lhcc_pkg::MissCost;
  assign sum_ext = {1'b0, sum_q} + {{(lhcc_pkg::SumW + 1 - lhcc_pkg::CostW){1'b0}}, cost};

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.update) begin
      sum_d = sum_ext[lhcc_pkg::SumW] ? '1 : sum_ext[lhcc_pkg::SumW-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      filled_q       <= '0;
      sum_q          <= '0;
      result_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q        <= valid_d;
      filled_q       <= filled_d;
      sum_q          <= sum_d;
      result_valid_q <= cmd_i.update;
      for (int i = 0; i < N; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_key_q <= city_key_i;
    end
    op_q  <= op_d;
    tgt_q <= tgt_d;
    if (cmd_i.update) begin
      hit_q <= (op_q == OP_HIT);
      if ((op_q == OP_FILL) || (op_q == OP_REPLACE)) begin
        keys_q[tgt_q] <= cur_key_q;
      end
    end
  end

  // Present the result
  assign result_valid_o = result_valid_q;
  assign hit_o          = hit_q;
  assign access_cost_o  = hit_q ? lhcc_pkg::HitCost : lhcc_pkg::MissCost;
  assign total_cost_o   = sum_q;

  // Valid entries are exactly the filled prefix count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(filled_q))
    else $error("valid bits disagree with fill count");

  // Fill count never exceeds the array depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= lhcc_pkg::CntW'(N))
    else $error("fill count overflow");

endmodule

@@ test/tb_lru_cache_hit_cost_counter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_cache_hit_cost_counter_core: self-checking bench of the LRU cost counter
// Walks a directed table of accesses and size writes, then random key streams
// over several cache sizes. Every result beat is checked field by field
// against a behavioral LRU model in the bench (fixed rows: typed-in hit, cost).
// ----------------------------------------------------------------------------
module tb_lru_cache_hit_cost_counter_core;

  localparam int unsigned NumDir   = 25;
  localparam int unsigned NumPhase = 8;
  localparam int unsigned PoolMax  = 40;
  localparam int unsigned PhaseLen = 65;
  localparam int unsigned DueDepth = 8;

  localparam logic [lhcc_pkg::KeyBits-1:0] KeyZero = '0;
  localparam logic [lhcc_pkg::KeyBits-1:0] KeyOnes = '1;
  localparam logic [lhcc_pkg::KeyBits-1:0] KeyA    = 64'h5555_5555_5555_5555;
  localparam logic [lhcc_pkg::KeyBits-1:0] KeyB    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [lhcc_pkg::KeyBits-1:0] KeyC    = 64'h0000_0000_0000_0001;
  localparam logic [lhcc_pkg::KeyBits-1:0] KeyD    = 64'h8000_0000_0000_0000;

  typedef enum logic {RowAccess, RowCfg} row_kind_e;

  // One row of the directed table; f_* hold a typed-in expectation when fixed is set
  typedef struct packed {
    row_kind_e                     kind;
    logic [lhcc_pkg::KeyBits-1:0]  val;
    logic                          fixed;
    logic                          f_hit;
    logic [lhcc_pkg::CostW-1:0]    f_cost;
  } dir_row_t;

  typedef struct packed {
    logic                          hit;
    logic [lhcc_pkg::CostW-1:0]    cost;
    logic [lhcc_pkg::SumW-1:0]     total;
  } access_res_t;

  logic                           clk_i      = 1'b0;
  logic                           rst_ni     = 1'b0;
  logic                           start      = 1'b0;
  logic                           busy;
  logic [lhcc_pkg::KeyBits-1:0]   city_key_i = '0;
  logic                           result_valid_o;
  logic                           hit_o;
  logic [lhcc_pkg::CostW-1:0]     access_cost_o;
  logic [lhcc_pkg::SumW-1:0]      total_cost_o;
  logic                           psel       = 1'b0;
  logic                           penable    = 1'b0;
  logic                           pwrite     = 1'b0;
  logic [lhcc_pkg::CfgAddrW-1:0]  paddr      = '0;
  logic [lhcc_pkg::CfgDataW-1:0]  pwdata     = '0;
  logic [lhcc_pkg::CfgDataW-1:0]  prdata;
  logic                           pready;

  // LRU model state
  logic [lhcc_pkg::KeyBits-1:0]   way_key  [lhcc_pkg::MaxEntries];
  logic                           way_used [lhcc_pkg::MaxEntries];
  logic [lhcc_pkg::AgeW-1:0]      way_age  [lhcc_pkg::MaxEntries];
  int unsigned                    fill_cnt;
  logic [lhcc_pkg::SumW-1:0]      cost_acc;
  logic [lhcc_pkg::SizeW-1:0]     size_cfg;

  // Expected beats in flight, oldest at the read pointer
  access_res_t                    due_buf [DueDepth];
  int unsigned                    due_wr = 0;
  int unsigned                    due_rd = 0;
  access_res_t                    exp_res;
  dir_row_t                       dir_steps [NumDir];
  int unsigned                    mismatch_cnt = 0;

  lru_cache_hit_cost_counter_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Drop every entry; the running total survives
  task automatic clear_ways();
    for (int i = 0; i < lhcc_pkg::MaxEntries; i++) begin
      way_key[i]  = '0;
      way_used[i] = 1'b0;
      way_age[i]  = '0;
    end
    fill_cnt = 0;
  endtask

  // Make way idx the most recent; younger valid ways age by one
  task automatic promote(input int unsigned idx, input int unsigned lim);
    logic [lhcc_pkg::AgeW-1:0] pivot;
    pivot = way_age[idx];
    for (int i = 0; i < lim; i++) begin
      if (i != idx && way_used[i] && way_age[i] < pivot && way_age[i] < lhcc_pkg::AgeMax)
        way_age[i] = way_age[i] + 1'b1;
    end
    way_age[idx] = '0;
  endtask

  // Look up one key, update recency and the total, return the result beat
  task automatic lru_access(input logic [lhcc_pkg::KeyBits-1:0] key,
                            output access_res_t res);
    int unsigned                lim;
    int unsigned                slot;
    logic                       found;
    logic [lhcc_pkg::CostW-1:0] cost;
    lim   = (size_cfg > lhcc_pkg::MaxEntries) ? lhcc_pkg::MaxEntries : size_cfg;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < lim; i++) begin
      if (!found && way_used[i] && way_key[i] == key) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      promote(slot, lim);
    end else if (lim > 0) begin
      if (fill_cnt < lim) begin
        // fill the next free way, everyone else ages
        for (int i = 0; i < lim; i++) begin
          if (way_used[i] && way_age[i] < lhcc_pkg::AgeMax)
            way_age[i] = way_age[i] + 1'b1;
        end
        slot           = fill_cnt;
        way_used[slot] = 1'b1;
        way_key[slot]  = key;
        way_age[slot]  = '0;
        fill_cnt++;
      end else begin
        // evict the oldest way, lowest index on a tie
        slot = 0;
        for (int i = 1; i < lim; i++) begin
          if (way_age[i] > way_age[slot])
            slot = i;
        end
        way_key[slot] = key;
        promote(slot, lim);
      end
    end
    cost = found ? lhcc_pkg::HitCost : lhcc_pkg::MissCost;
    if (cost_acc > {lhcc_pkg::SumW{1'b1}} - lhcc_pkg::SumW'(cost))
      cost_acc = {lhcc_pkg::SumW{1'b1}};
    else
      cost_acc = cost_acc + lhcc_pkg::SumW'(cost);
    res.hit   = found;
    res.cost  = cost;
    res.total = cost_acc;
  endtask

  // Offer one key, hold it until accepted, then queue its expected beat
  task automatic send_key(input logic [lhcc_pkg::KeyBits-1:0] key, input logic fixed,
                          input logic f_hit, input logic [lhcc_pkg::CostW-1:0] f_cost);
    access_res_t res;
    start      <= 1'b1;
    city_key_i <= key;
    do @(posedge clk_i); while (busy);
    lru_access(key, res);
    if (fixed) begin
      res.hit  = f_hit;
      res.cost = f_cost;
    end
    due_buf[due_wr % DueDepth] = res;
    due_wr++;
  endtask

  // Random pause of the sender: none when calm, else mostly none, some short, a few long
  task automatic idle_gap(input bit calm);
    int unsigned n;
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55)
      n = 0;
    else if (r < 90)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(4, 24);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every expected beat has come back
  task automatic drain_results();
    start <= 1'b0;
    while (due_wr != due_rd) @(posedge clk_i);
  endtask

  // Write cache_size while idle, flush the model, read the register back
  task automatic cfg_write(input logic [lhcc_pkg::CfgDataW-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= lhcc_pkg::CfgAddrW'({lhcc_pkg::CfgIdxCacheSize, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    size_cfg = value[lhcc_pkg::SizeW-1:0];
    clear_ways();
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== lhcc_pkg::CfgDataW'(size_cfg)) begin
      $display("%0t: cache_size read back expected %0d actual %0d", $time, size_cfg, prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase: set the size, then stream keys from a pool one to four larger than the clamped size
  task automatic run_phase(input logic [lhcc_pkg::SizeW-1:0] size);
    logic [lhcc_pkg::KeyBits-1:0]  pool [PoolMax];
    logic [lhcc_pkg::KeyBits-1:0]  key;
    logic [lhcc_pkg::CfgDataW-1:0] cfg_val;
    int unsigned                   lim;
    int unsigned                   pool_n;
    int unsigned                   r;
    bit                            calm;
    cfg_val                        = $urandom();
    cfg_val[lhcc_pkg::SizeW-1:0]   = size;
    cfg_write(cfg_val);
    lim    = (size > lhcc_pkg::MaxEntries) ? lhcc_pkg::MaxEntries : size;
    pool_n = lim + $urandom_range(1, 4);
    for (int i = 0; i < pool_n; i++) begin
      r = $urandom_range(15);
      pool[i] = (r == 0) ? KeyZero : (r == 1) ? KeyOnes : {$urandom(), $urandom()};
    end
    calm = ($urandom_range(3) == 0);
    for (int n = 0; n < PhaseLen; n++) begin
      r   = $urandom_range(99);
      key = pool[$urandom_range(pool_n - 1)];
      if (r >= 92)
        key = {$urandom(), $urandom()};
      else if (r >= 85)
        key[$urandom_range(lhcc_pkg::KeyBits - 1)] ^= 1'b1;  // near miss on one bit
      send_key(key, 1'b0, 1'b0, lhcc_pkg::MissCost);
      if ($urandom_range(49) == 0)
        drain_results();
      else
        idle_gap(calm);
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (due_wr == due_rd) begin
        $display("%0t: unexpected beat: hit %0b cost %0d total %0d",
                 $time, hit_o, access_cost_o, total_cost_o);
        mismatch_cnt++;
      end else begin
        exp_res = due_buf[due_rd % DueDepth];
        due_rd++;
        if (hit_o !== exp_res.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, hit_o);
          mismatch_cnt++;
        end
        if (access_cost_o !== exp_res.cost) begin
          $display("%0t: access_cost expected %0d actual %0d",
                   $time, exp_res.cost, access_cost_o);
          mismatch_cnt++;
        end
        if (total_cost_o !== exp_res.total) begin
          $display("%0t: total_cost expected %0d actual %0d",
                   $time, exp_res.total, total_cost_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** lru_cache_hit_cost_counter_core: FAILED **");
    $finish;
  end

  initial begin
    logic [lhcc_pkg::SizeW-1:0] size;
    // size 0 misses everything, size 1 thrashes, fill-time hits, masked
    // oversize write, then LRU order in a two-way cache
    dir_steps = '{
      '{RowAccess, KeyZero, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyOnes, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowCfg,    64'd1,   1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b1, lhcc_pkg::HitCost},
      '{RowAccess, KeyOnes, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowCfg,    64'd32,  1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyA,    1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyB,    1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyA,    1'b1, 1'b1, lhcc_pkg::HitCost},
      '{RowAccess, KeyC,    1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyD,    1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyB,    1'b1, 1'b1, lhcc_pkg::HitCost},
      '{RowCfg,    64'hFFFF_FFFF, 1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyA,    1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyA,    1'b1, 1'b1, lhcc_pkg::HitCost},
      '{RowCfg,    64'd2,   1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyOnes, 1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b1, lhcc_pkg::HitCost},
      '{RowAccess, KeyA,    1'b0, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyOnes, 1'b1, 1'b0, lhcc_pkg::MissCost},
      '{RowAccess, KeyZero, 1'b1, 1'b0, lhcc_pkg::MissCost}
    };
    clear_ways();
    size_cfg = '0;
    cost_acc = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (int i = 0; i < NumDir; i++) begin
      if (dir_steps[i].kind == RowCfg) begin
        cfg_write(dir_steps[i].val[lhcc_pkg::CfgDataW-1:0]);
      end else begin
        send_key(dir_steps[i].val, dir_steps[i].fixed, dir_steps[i].f_hit,
                 dir_steps[i].f_cost);
        idle_gap(1'b0);
      end
    end

    // Random phases over small, full, zero, single, oversized and mid sizes
    for (int p = 0; p < NumPhase; p++) begin
      case (p)
        0:       size = 6'd4;
        1:       size = 6'd32;
        2:       size = 6'd0;
        3:       size = 6'd1;
        4:       size = lhcc_pkg::SizeW'($urandom_range(33, 63));
        5:       size = 6'd2;
        6:       size = lhcc_pkg::SizeW'($urandom_range(3, 31));
        default: size = 6'd16;
      endcase
      run_phase(size);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("** lru_cache_hit_cost_counter_core: PASSED **");
    else
      $display("** lru_cache_hit_cost_counter_core: FAILED **");
    $finish;
  end

endmodule
